### hw/rtl/bhc_pkg.sv
// ----------------------------------------------------------------------------
// bhc_pkg
// Shared types, register indexes and reset values for the button hold
// classifier.
// ----------------------------------------------------------------------------
package bhc_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_SETTLE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_POLL      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OVERLAY   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SHIP      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SHORT_MAX = 3'd5;

  // Register reset values
  localparam logic [15:0] SETTLE_RST    = 16'd500;
  localparam logic [7:0]  DEBOUNCE_RST  = 8'd15;
  localparam logic [7:0]  POLL_RST      = 8'd50;
  localparam logic [15:0] OVERLAY_RST   = 16'd2500;
  localparam logic [15:0] SHIP_RST      = 16'd3000;
  localparam logic [15:0] SHORT_MAX_RST = 16'd1000;

  // Hold counter saturation value
  localparam logic [15:0] HOLD_MAX = 16'hFFFF;

  // Configuration register set
  typedef struct packed {
    logic [15:0] settle_ms;
    logic [7:0]  debounce_ms;
    logic [7:0]  poll_ms;
    logic [15:0] overlay_ms;
    logic [15:0] ship_ms;
    logic [15:0] short_max_ms;
  } cfg_t;

  // Classifier phases
  typedef enum logic [2:0] {
    PH_SETTLING = 3'd0,
    PH_IDLE     = 3'd1,
    PH_DEBOUNCE = 3'd2,
    PH_HOLDING  = 3'd3,
    PH_SHUTDOWN = 3'd4
  } phase_t;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_WAKE  = 2'd1,
    EV_SLEEP = 2'd2,
    EV_SHIP  = 2'd3
  } event_t;

endpackage

### hw/rtl/bhc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bhc_cfg_regs
// Configuration register file: decodes writes by index, masks data to each
// register's width and presents the set as one struct.
// ----------------------------------------------------------------------------
module bhc_cfg_regs
  import bhc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  // Always able to take a write
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid & cfg_ready;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_index)
        REG_SETTLE:    cfg_nxt.settle_ms    = cfg_data;
        REG_DEBOUNCE:  cfg_nxt.debounce_ms  = cfg_data[7:0];
        REG_POLL:      cfg_nxt.poll_ms      = cfg_data[7:0];
        REG_OVERLAY:   cfg_nxt.overlay_ms   = cfg_data;
        REG_SHIP:      cfg_nxt.ship_ms      = cfg_data;
        REG_SHORT_MAX: cfg_nxt.short_max_ms = cfg_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the register set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ms    <= SETTLE_RST;
      cfg_r.debounce_ms  <= DEBOUNCE_RST;
      cfg_r.poll_ms      <= POLL_RST;
      cfg_r.overlay_ms   <= OVERLAY_RST;
      cfg_r.ship_ms      <= SHIP_RST;
      cfg_r.short_max_ms <= SHORT_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/button_hold_classifier_core.sv
// ----------------------------------------------------------------------------
// button_hold_classifier_core
// Classifies button holds from one millisecond tick per transaction: settle,
// debounce, timed hold sampling, overlay warning, shutdown latch and
// short-press wake/sleep events.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in_     | in        | in_valid / in_stall    | in_button_down, in_display_asleep
//  out_    | out       | out_valid / out_stall  | out_event_code, out_overlay_on,
//          |           |                        | out_shutdown_on
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One transaction per cycle sustained while out_stall is low; each item passes
//  the input register, then the result register. The classifier state advances
//  in the cycle an item moves from the input register into the result register.
//  Reset (synchronous, rst_n low) loads the register reset values and puts
//  the classifier in its settling phase with all counters clear.
//  A stalled output holds its result; the input register still fills once
//  while the output is stalled, then in_stall rises. cfg_ready is always high.
// ----------------------------------------------------------------------------
module button_hold_classifier_core
  import bhc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_button_down,
  input  logic                in_display_asleep,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_event_code,
  output logic                out_overlay_on,
  output logic                out_shutdown_on,
  // Configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t cfg;

  // Input register
  logic in_valid_r;
  logic down_r;
  logic asleep_r;

  // Result register
  logic       out_valid_r;
  event_t     event_r;
  logic       overlay_out_r;
  logic       shutdown_out_r;

  // Classifier state
  phase_t      phase_r,       phase_nxt;
  logic [15:0] phase_ticks_r, phase_ticks_nxt;
  logic [15:0] hold_ticks_r,  hold_ticks_nxt;
  logic [7:0]  poll_ticks_r,  poll_ticks_nxt;
  logic        overlay_r,     overlay_nxt;
  logic        shutdown_r,    shutdown_nxt;
  event_t      event_nxt;

  // Pipeline control
  logic out_load;
  logic step;
  logic in_take;

  // Working values
  phase_t      phase_eff;
  logic [15:0] phase_inc;
  logic [15:0] hold_inc;
  logic [7:0]  poll_inc;

  bhc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance when the result register is free or being drained
  assign out_load = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_load;
  assign in_stall = in_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      down_r   <= in_button_down;
      asleep_r <= in_display_asleep;
    end
  end

  // Next classifier state and event for the item in the input register
  always_comb begin
    phase_nxt       = phase_r;
    phase_ticks_nxt = phase_ticks_r;
    hold_ticks_nxt  = hold_ticks_r;
    poll_ticks_nxt  = poll_ticks_r;
    overlay_nxt     = overlay_r;
    shutdown_nxt    = shutdown_r;
    event_nxt       = EV_NONE;
    phase_eff       = phase_r;

    phase_inc = phase_ticks_r + 16'd1;
    hold_inc  = (hold_ticks_r == HOLD_MAX) ? hold_ticks_r : hold_ticks_r + 16'd1;
    poll_inc  = poll_ticks_r + 8'd1;

    // Count settle ticks; once done, fall through to idle this tick
    if (phase_r == PH_SETTLING) begin
      if (phase_ticks_r < cfg.settle_ms) begin
        phase_ticks_nxt = phase_inc;
      end else begin
        phase_eff = PH_IDLE;
      end
    end
    phase_nxt = phase_eff;

    case (phase_eff)
      PH_IDLE: begin
        if (down_r) begin
          phase_nxt       = PH_DEBOUNCE;
          phase_ticks_nxt = 16'd0;
        end
      end
      PH_DEBOUNCE: begin
        phase_ticks_nxt = phase_inc;
        if (phase_inc >= {8'd0, cfg.debounce_ms}) begin
          phase_ticks_nxt = 16'd0;
          if (down_r) begin
            phase_nxt      = PH_HOLDING;
            hold_ticks_nxt = 16'd0;
            poll_ticks_nxt = 8'd0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_HOLDING: begin
        hold_ticks_nxt = hold_inc;
        poll_ticks_nxt = poll_inc;
        // Sample the hold once per poll interval
        if (poll_inc >= cfg.poll_ms) begin
          poll_ticks_nxt = 8'd0;
          if (hold_inc >= cfg.overlay_ms) begin
            overlay_nxt = 1'b1;
          end
          if (down_r && (hold_inc >= cfg.ship_ms)) begin
            shutdown_nxt = 1'b1;
            phase_nxt    = PH_SHUTDOWN;
            event_nxt    = EV_SHIP;
          end else if (!down_r) begin
            overlay_nxt = 1'b0;
            phase_nxt   = PH_IDLE;
            if (hold_inc < cfg.short_max_ms) begin
              event_nxt = asleep_r ? EV_WAKE : EV_SLEEP;
            end
          end
        end
      end
      default: begin
        // Settling still counting, or shutdown: nothing changes
      end
    endcase
  end

  // Hold the classifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SETTLING;
      phase_ticks_r <= 16'd0;
      hold_ticks_r  <= 16'd0;
      poll_ticks_r  <= 8'd0;
      overlay_r     <= 1'b0;
      shutdown_r    <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      phase_ticks_r <= phase_ticks_nxt;
      hold_ticks_r  <= hold_ticks_nxt;
      poll_ticks_r  <= poll_ticks_nxt;
      overlay_r     <= overlay_nxt;
      shutdown_r    <= shutdown_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      event_r        <= event_nxt;
      overlay_out_r  <= overlay_nxt;
      shutdown_out_r <= shutdown_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_code  = event_r;
  assign out_overlay_on  = overlay_out_r;
  assign out_shutdown_on = shutdown_out_r;

endmodule

### tb/tb_button_hold_classifier_core.sv
// ----------------------------------------------------------------------------
// tb_button_hold_classifier_core
// Self-checking bench for the button hold classifier. A short directed plan
// walks the settle, debounce, wake, sleep, overlay and release paths; random
// phases then replay presses, bounces and noise under varied register
// settings. A final hold latches shutdown. Every result is compared against
// the typed result of its plan row or else a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_button_hold_classifier_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bhc_pkg::*;

  localparam int unsigned RANDOM_TICKS   = 1400;
  localparam int unsigned QUIET_CYCLES   = 4;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam int          PLAN_LEN       = 33;

  typedef struct packed {
    event_t ev;
    logic   ov;
    logic   sd;
  } tick_result_t;

  // One row of the directed plan: a register write or a tick
  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic                dn;
    logic                asl;
    logic                typed;
    tick_result_t        res;
  } step_t;

  function automatic step_t reg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    step_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic step_t tick_row(logic dn, logic asl);
    step_t r;
    r = '0;
    r.dn = dn;
    r.asl = asl;
    return r;
  endfunction

  function automatic step_t tick_chk(logic dn, logic asl, event_t ev, logic ov, logic sd);
    step_t r;
    r = '0;
    r.dn = dn;
    r.asl = asl;
    r.typed = 1'b1;
    r.res.ev = ev;
    r.res.ov = ov;
    r.res.sd = sd;
    return r;
  endfunction

  // Directed plan: settle at its maximum, then tiny thresholds with masked
  // debounce and poll of zero so every tick is a sample
  localparam step_t PLAN [PLAN_LEN] = '{
    reg_row(REG_SETTLE, 16'hFFFF),
    // settling ignores the button
    tick_chk(1'b1, 1'b0, EV_NONE, 1'b0, 1'b0),
    tick_chk(1'b1, 1'b1, EV_NONE, 1'b0, 1'b0),
    tick_chk(1'b0, 1'b1, EV_NONE, 1'b0, 1'b0),
    reg_row(REG_SETTLE, 16'h0000),
    reg_row(REG_DEBOUNCE, 16'hFF00),
    reg_row(REG_POLL, 16'h1200),
    reg_row(REG_OVERLAY, 16'd3),
    reg_row(REG_SHIP, 16'hFFFF),
    reg_row(REG_SHORT_MAX, 16'd2),
    reg_row(3'd6, 16'h0001),
    reg_row(3'd7, 16'hFFFF),
    // button already down when idle is entered, short press while asleep
    tick_row(1'b1, 1'b0),
    tick_row(1'b1, 1'b0),
    tick_chk(1'b0, 1'b1, EV_WAKE, 1'b0, 1'b0),
    // short press while awake
    tick_row(1'b1, 1'b1),
    tick_row(1'b1, 1'b0),
    tick_chk(1'b0, 1'b0, EV_SLEEP, 1'b0, 1'b0),
    // hold past the overlay threshold, then release past the short limit
    tick_row(1'b1, 1'b0),
    tick_row(1'b1, 1'b1),
    tick_row(1'b1, 1'b0),
    tick_row(1'b1, 1'b0),
    tick_chk(1'b1, 1'b0, EV_NONE, 1'b1, 1'b0),
    tick_row(1'b1, 1'b1),
    tick_row(1'b0, 1'b1),
    // released at the debounce check
    tick_row(1'b1, 1'b0),
    tick_row(1'b0, 1'b0),
    tick_row(1'b0, 1'b1),
    // release on the very sample that reaches the overlay threshold
    tick_row(1'b1, 1'b0),
    tick_row(1'b1, 1'b0),
    tick_row(1'b1, 1'b1),
    tick_row(1'b1, 1'b1),
    tick_row(1'b0, 1'b1)
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_button_down;
  logic                in_display_asleep;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_event_code;
  logic                out_overlay_on;
  logic                out_shutdown_on;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // Predictor state and register copy
  cfg_t        regs;
  phase_t      cls_phase;
  logic [15:0] phase_cnt;
  logic [15:0] hold_cnt;
  logic [7:0]  poll_cnt;
  logic        overlay_lvl;
  logic        shutdown_lvl;

  tick_result_t tick_results_due [$];
  int unsigned  errors;
  int unsigned  ticks_sent;
  bit           no_idle;

  button_hold_classifier_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_button_down    (in_button_down),
    .in_display_asleep (in_display_asleep),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_code    (out_event_code),
    .out_overlay_on    (out_overlay_on),
    .out_shutdown_on   (out_shutdown_on),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void reset_classifier();
    regs = '{settle_ms: SETTLE_RST, debounce_ms: DEBOUNCE_RST, poll_ms: POLL_RST,
             overlay_ms: OVERLAY_RST, ship_ms: SHIP_RST, short_max_ms: SHORT_MAX_RST};
    cls_phase = PH_SETTLING;
    phase_cnt = '0;
    hold_cnt = '0;
    poll_cnt = '0;
    overlay_lvl = 1'b0;
    shutdown_lvl = 1'b0;
  endfunction

  // Mirror a register write; narrow registers keep the low byte
  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      REG_SETTLE:    regs.settle_ms = data;
      REG_DEBOUNCE:  regs.debounce_ms = data[7:0];
      REG_POLL:      regs.poll_ms = data[7:0];
      REG_OVERLAY:   regs.overlay_ms = data;
      REG_SHIP:      regs.ship_ms = data;
      REG_SHORT_MAX: regs.short_max_ms = data;
      default: ;
    endcase
  endfunction

  // Advance the classifier by one millisecond tick
  function automatic void classify_tick(input logic dn, input logic asl,
                                        output tick_result_t r);
    event_t ev;
    ev = EV_NONE;
    if (cls_phase == PH_SETTLING) begin
      if (phase_cnt < regs.settle_ms) phase_cnt++;
      else cls_phase = PH_IDLE;
    end
    case (cls_phase)
      PH_IDLE: begin
        if (dn) begin
          cls_phase = PH_DEBOUNCE;
          phase_cnt = '0;
        end
      end
      PH_DEBOUNCE: begin
        phase_cnt++;
        if (phase_cnt >= regs.debounce_ms) begin
          if (dn) begin
            cls_phase = PH_HOLDING;
            hold_cnt = '0;
            poll_cnt = '0;
          end else begin
            cls_phase = PH_IDLE;
          end
          phase_cnt = '0;
        end
      end
      PH_HOLDING: begin
        if (hold_cnt != HOLD_MAX) hold_cnt++;
        poll_cnt++;
        if (poll_cnt >= regs.poll_ms) begin
          poll_cnt = '0;
          if (hold_cnt >= regs.overlay_ms) overlay_lvl = 1'b1;
          if (dn && hold_cnt >= regs.ship_ms) begin
            shutdown_lvl = 1'b1;
            cls_phase = PH_SHUTDOWN;
            ev = EV_SHIP;
          end else if (!dn) begin
            overlay_lvl = 1'b0;
            if (hold_cnt < regs.short_max_ms) begin
              if (asl) ev = EV_WAKE;
              else ev = EV_SLEEP;
            end
            cls_phase = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
    r.ev = ev;
    r.ov = overlay_lvl;
    r.sd = shutdown_lvl;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(0, 2);
    return $urandom_range(3, 24);
  endfunction

  function automatic int unsigned hold_target();
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, 12);
      1:       return $urandom_range(0, 80);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // Send one tick; queue the typed result when given, else the prediction
  task automatic send_tick(input logic dn, input logic asl, input logic typed = 1'b0,
                           input tick_result_t want = '0);
    int unsigned gap;
    tick_result_t pred;
    gap = idle_len();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_button_down = dn;
    in_display_asleep = asl;
    do @(posedge clk); while (in_stall);
    classify_tick(dn, asl, pred);
    tick_results_due.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  // Write a register once every outstanding result has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    in_valid = 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Pick a register set per phase, leaning on the extremes
  task automatic pick_phase_regs();
    logic [15:0] v;
    logic [7:0]  hi;
    case ($urandom_range(0, 2))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom_range(1, 65534));
    endcase
    write_reg(REG_SETTLE, v);
    hi = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       v = {hi, 8'd0};
      1:       v = {hi, 8'd1};
      2:       v = {hi, 8'd255};
      default: v = {hi, 8'($urandom_range(2, 6))};
    endcase
    write_reg(REG_DEBOUNCE, v);
    hi = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       v = {hi, 8'd0};
      1:       v = {hi, 8'd1};
      2:       v = {hi, 8'd255};
      default: v = {hi, 8'($urandom_range(2, 9))};
    endcase
    write_reg(REG_POLL, v);
    case ($urandom_range(0, 3))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom_range(1, 80));
    endcase
    write_reg(REG_OVERLAY, v);
    // keep ship out of reach so shutdown waits for the last phase
    if ($urandom_range(0, 1) != 0) v = 16'hFFFF;
    else v = 16'($urandom_range(1500, 65534));
    write_reg(REG_SHIP, v);
    case ($urandom_range(0, 3))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom_range(1, 60));
    endcase
    write_reg(REG_SHORT_MAX, v);
  endtask

  // Presses with random content, plus bounces and raw noise
  task automatic run_presses(input int unsigned budget);
    int unsigned stop_at;
    int unsigned deb_eff;
    int unsigned poll_eff;
    int unsigned kind;
    stop_at = ticks_sent + budget;
    deb_eff = (regs.debounce_ms == 0) ? 1 : regs.debounce_ms;
    poll_eff = (regs.poll_ms == 0) ? 1 : regs.poll_ms;
    while (ticks_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        repeat ($urandom_range(0, 4)) send_tick(1'b0, 1'($urandom));
        repeat (deb_eff + 1 + hold_target()) send_tick(1'b1, 1'($urandom));
        repeat (poll_eff + 2) send_tick(1'b0, 1'($urandom));
      end else if (kind < 8) begin
        repeat ($urandom_range(1, deb_eff)) send_tick(1'b1, 1'($urandom));
        repeat (deb_eff + 1) send_tick(1'b0, 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic flush_to_idle();
    while (cls_phase != PH_IDLE) send_tick(1'b0, 1'($urandom));
  endtask

  // Stall the result channel in random bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        stall_left = ($urandom_range(0, 1) != 0) ? idle_len() : 0;
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tick_results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result event=%0d overlay=%0b shutdown=%0b",
                 $time, out_event_code, out_overlay_on, out_shutdown_on);
      end else begin
        want = tick_results_due.pop_front();
        if (out_event_code !== want.ev) begin
          errors++;
          $display("%0t: event_code expected %0d got %0d", $time, want.ev, out_event_code);
        end
        if (out_overlay_on !== want.ov) begin
          errors++;
          $display("%0t: overlay_on expected %0b got %0b", $time, want.ov, out_overlay_on);
        end
        if (out_shutdown_on !== want.sd) begin
          errors++;
          $display("%0t: shutdown_on expected %0b got %0b", $time, want.sd, out_shutdown_on);
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #80_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned random_start;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_button_down = 1'b0;
    in_display_asleep = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    ticks_sent = 0;
    no_idle = 1'b0;
    reset_classifier();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed plan
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].is_cfg) write_reg(PLAN[i].idx, PLAN[i].data);
      else send_tick(PLAN[i].dn, PLAN[i].asl, PLAN[i].typed, PLAN[i].res);
    end

    // Random phases, each with its own register set
    random_start = ticks_sent;
    while (ticks_sent - random_start < RANDOM_TICKS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      pick_phase_regs();
      run_presses($urandom_range(120, 220));
    end
    no_idle = 1'b0;

    // Latch shutdown below the overlay threshold, then feed ignored input
    flush_to_idle();
    write_reg(REG_OVERLAY, 16'hFFFF);
    write_reg(REG_SHIP, 16'd0);
    write_reg(REG_POLL, 16'($urandom_range(1, 5)));
    write_reg(REG_DEBOUNCE, 16'($urandom_range(1, 4)));
    repeat (regs.debounce_ms + regs.poll_ms + 3) send_tick(1'b1, 1'($urandom));
    repeat (30) send_tick(1'($urandom), 1'($urandom));

    // Drain and report
    @(negedge clk);
    in_valid = 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && tick_results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/bhc_pkg.sv
hw/rtl/bhc_cfg_regs.sv
hw/rtl/button_hold_classifier_core.sv
tb/tb_button_hold_classifier_core.sv
